// ===== design/fir_filter_direct_form_core_defines.svh =====
// Assertion macros shared by the FIR filter checker.
`ifndef FIR_FILTER_DIRECT_FORM_CORE_DEFINES_SVH
`define FIR_FILTER_DIRECT_FORM_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FIR_DF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fir_df check failed");

// Next-cycle implication, disabled during reset.
`define FIR_DF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fir_df check failed");

`endif

// ===== design/fir_df_pkg.sv =====
// Package with constants, payload types and control structs of the FIR filter.
package fir_df_pkg;

  localparam int MAX_TAPS        = 1024;
  localparam int SAMPLE_BITS     = 16;
  localparam int COEF_BITS       = 16;
  localparam int FRAC_BITS       = 15;
  localparam int TAP_INDEX_BITS  = 10;
  localparam int TAP_COUNT_BITS  = 11;
  localparam int TAP_COUNT_RESET = 50;
  localparam int ADDR_BITS       = $clog2(MAX_TAPS);
  localparam int CNT_BITS        = $clog2(MAX_TAPS + 1);
  localparam int PROD_BITS       = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS        = PROD_BITS + ADDR_BITS;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TAP    = 1'b1;

  typedef struct packed {
    logic                          command;
    logic [TAP_INDEX_BITS-1:0]     tap_index;
    logic signed [COEF_BITS-1:0]   tap_value;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          saturated;
  } out_t;

  typedef struct packed {
    logic clear_step;
    logic load_sample;
    logic load_tap;
    logic mac_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mac_last;
    logic taps_zero;
    logic pipe_busy;
  } status_t;

endpackage

// ===== design/fir_df_ram.sv =====
// Generic simple dual-port RAM with registered read.
module fir_df_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fir_df_datapath.sv =====
// Datapath: tap and delay RAMs, index counter, shared MAC, shift and saturate.
module fir_df_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [fir_df_pkg::TAP_COUNT_BITS-1:0] cfg_data,
  input  fir_df_pkg::in_t                       in_data,
  input  fir_df_pkg::cmd_t                      cmd,
  output fir_df_pkg::status_t                   status,
  output fir_df_pkg::out_t                      out_data
);

  localparam int POS_BITS = fir_df_pkg::ADDR_BITS + 1;

  logic [fir_df_pkg::TAP_COUNT_BITS-1:0]   tap_count;
  logic [fir_df_pkg::ADDR_BITS-1:0]        newest;
  logic [fir_df_pkg::ADDR_BITS-1:0]        idx;
  logic                                    rd_v;
  logic                                    prod_v;
  logic signed [fir_df_pkg::PROD_BITS-1:0] prod;
  logic signed [fir_df_pkg::ACC_BITS-1:0]  acc;

  logic [fir_df_pkg::CNT_BITS-1:0]         n_taps;
  logic [fir_df_pkg::ADDR_BITS-1:0]        newest_dec;
  logic [fir_df_pkg::ADDR_BITS-1:0]        idx_inc;
  logic [POS_BITS-1:0]                     pos_sum;
  logic [fir_df_pkg::ADDR_BITS-1:0]        rd_pos;
  logic                                    tap_ok;

  logic                                    d_we;
  logic [fir_df_pkg::ADDR_BITS-1:0]        d_waddr;
  logic [fir_df_pkg::SAMPLE_BITS-1:0]      d_wdata;
  logic [fir_df_pkg::SAMPLE_BITS-1:0]      d_rdata;
  logic                                    t_we;
  logic [fir_df_pkg::ADDR_BITS-1:0]        t_waddr;
  logic [fir_df_pkg::COEF_BITS-1:0]        t_wdata;
  logic [fir_df_pkg::COEF_BITS-1:0]        t_rdata;

  logic signed [fir_df_pkg::ACC_BITS-1:0]  shifted;
  logic [fir_df_pkg::ACC_BITS-fir_df_pkg::SAMPLE_BITS:0] upper;
  logic                                    fits;
  fir_df_pkg::out_t                        result;

  always_comb begin
    n_taps = (int'(tap_count) > fir_df_pkg::MAX_TAPS)
             ? fir_df_pkg::CNT_BITS'(fir_df_pkg::MAX_TAPS)
             : fir_df_pkg::CNT_BITS'(tap_count);
    newest_dec = (newest == '0) ? fir_df_pkg::ADDR_BITS'(fir_df_pkg::MAX_TAPS - 1)
                                : newest - fir_df_pkg::ADDR_BITS'(1);
    idx_inc = (idx == fir_df_pkg::ADDR_BITS'(fir_df_pkg::MAX_TAPS - 1))
              ? '0 : idx + fir_df_pkg::ADDR_BITS'(1);
    pos_sum = POS_BITS'(newest) + POS_BITS'(idx);
    rd_pos = (int'(pos_sum) >= fir_df_pkg::MAX_TAPS)
             ? fir_df_pkg::ADDR_BITS'(pos_sum - POS_BITS'(fir_df_pkg::MAX_TAPS))
             : fir_df_pkg::ADDR_BITS'(pos_sum);
    tap_ok = int'(in_data.tap_index) < fir_df_pkg::MAX_TAPS;

    d_we    = cmd.clear_step | cmd.load_sample;
    d_waddr = cmd.clear_step ? idx : newest_dec;
    d_wdata = cmd.clear_step ? '0 : in_data.sample;
    t_we    = cmd.clear_step | (cmd.load_tap & tap_ok);
    t_waddr = cmd.clear_step ? idx : fir_df_pkg::ADDR_BITS'(in_data.tap_index);
    t_wdata = cmd.clear_step ? '0 : in_data.tap_value;

    status.clear_last = (idx == fir_df_pkg::ADDR_BITS'(fir_df_pkg::MAX_TAPS - 1));
    status.mac_last   = (fir_df_pkg::CNT_BITS'(idx) + fir_df_pkg::CNT_BITS'(1)) == n_taps;
    status.taps_zero  = (n_taps == '0);
    status.pipe_busy  = rd_v | prod_v;

    shifted = acc >>> fir_df_pkg::FRAC_BITS;
    upper   = shifted[fir_df_pkg::ACC_BITS-1:fir_df_pkg::SAMPLE_BITS-1];
    fits    = (&upper) | (~|upper);
    result.saturated = ~fits;
    if (fits) begin
      result.filtered = shifted[fir_df_pkg::SAMPLE_BITS-1:0];
    end else if (shifted[fir_df_pkg::ACC_BITS-1]) begin
      result.filtered = {1'b1, {(fir_df_pkg::SAMPLE_BITS-1){1'b0}}};
    end else begin
      result.filtered = {1'b0, {(fir_df_pkg::SAMPLE_BITS-1){1'b1}}};
    end
  end

  fir_df_ram #(
    .WIDTH(fir_df_pkg::SAMPLE_BITS),
    .DEPTH(fir_df_pkg::MAX_TAPS)
  ) u_delay_ram (
    .clk  (clk),
    .we   (d_we),
    .waddr(d_waddr),
    .wdata(d_wdata),
    .raddr(rd_pos),
    .rdata(d_rdata)
  );

  fir_df_ram #(
    .WIDTH(fir_df_pkg::COEF_BITS),
    .DEPTH(fir_df_pkg::MAX_TAPS)
  ) u_tap_ram (
    .clk  (clk),
    .we   (t_we),
    .waddr(t_waddr),
    .wdata(t_wdata),
    .raddr(idx),
    .rdata(t_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= fir_df_pkg::TAP_COUNT_BITS'(fir_df_pkg::TAP_COUNT_RESET);
      newest    <= '0;
      idx       <= '0;
      rd_v      <= 1'b0;
      prod_v    <= 1'b0;
    end else begin
      if (cfg_write) begin
        tap_count <= cfg_data;
      end
      if (cmd.load_sample) begin
        newest <= newest_dec;
      end
      if (cmd.load_sample) begin
        idx <= '0;
      end else if (cmd.clear_step | cmd.mac_step) begin
        idx <= idx_inc;
      end
      rd_v   <= cmd.mac_step;
      prod_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(d_rdata) * $signed(t_rdata);
    if (cmd.load_sample) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + fir_df_pkg::ACC_BITS'(prod);
    end
    if (cmd.finish) begin
      out_data <= result;
    end
  end

endmodule

// ===== design/fir_df_ctrl.sv =====
// Controller: RAM clearing pass, transaction acceptance and tap sequencing.
module fir_df_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_command,
  input  logic                out_stall,
  input  fir_df_pkg::status_t status,
  output fir_df_pkg::cmd_t    cmd,
  output logic                in_stall,
  output logic                out_valid
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MAC    = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       out_free;

  always_comb begin
    in_stall        = (state != ST_IDLE);
    accept          = (state == ST_IDLE) & in_valid;
    out_free        = ~out_valid | ~out_stall;
    cmd.clear_step  = (state == ST_CLEAR);
    cmd.load_sample = accept & (in_command == fir_df_pkg::CMD_SAMPLE);
    cmd.load_tap    = accept & (in_command == fir_df_pkg::CMD_TAP);
    cmd.mac_step    = (state == ST_MAC);
    cmd.finish      = (state == ST_FINISH) & out_free;

    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.load_sample) state_next = status.taps_zero ? ST_FINISH : ST_MAC;
      end
      ST_MAC: begin
        if (status.mac_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/fir_filter_direct_form_core.sv =====
// Top level of the direct-form FIR filter: controller plus datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_data   (fir_df_pkg::in_t)
//   out      output     out_valid / out_stall  out_data  (fir_df_pkg::out_t)
//   cfg      input      cfg_write              cfg_data  (tap_count)
//
// A tap write leaves in_stall low. A sample is filtered over n = min(tap_count, 1024) taps
// (none when n is 0) by the single shared multiply-accumulate, which reads one tap per cycle.
// After reset a pass clears every entry of both RAMs; in_stall stays high meanwhile.
// A finished result waits in the output register while the next transaction is taken.
module fir_filter_direct_form_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  fir_df_pkg::in_t                       in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output fir_df_pkg::out_t                      out_data,
  input  logic                                  cfg_write,
  input  logic [fir_df_pkg::TAP_COUNT_BITS-1:0] cfg_data
);

  fir_df_pkg::cmd_t    cmd;
  fir_df_pkg::status_t status;

  fir_df_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_command(in_data.command),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  fir_df_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== design/fir_df_checker.sv =====
// Port-level checker for the FIR filter and its bind to the top level.
`include "fir_filter_direct_form_core_defines.svh"

module fir_df_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input fir_df_pkg::in_t  in_data,
  input logic             out_valid,
  input logic             out_stall,
  input fir_df_pkg::out_t out_data
);

  `FIR_DF_ASSERT_NEXT(a_sample_busy, clk, rst,
    in_valid && !in_stall && in_data.command == fir_df_pkg::CMD_SAMPLE, in_stall)
  `FIR_DF_ASSERT_NEXT(a_tap_write_quick, clk, rst,
    in_valid && !in_stall && in_data.command == fir_df_pkg::CMD_TAP, !in_stall)
  `FIR_DF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, $stable(out_data))
  `FIR_DF_ASSERT_NOW(a_sat_clip, clk, rst, out_valid && out_data.saturated,
    out_data.filtered == 16'sh7fff || out_data.filtered == 16'sh8000)

endmodule

bind fir_filter_direct_form_core fir_df_checker u_fir_df_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the direct-form FIR filter core with tap writes and samples.
module tb;
  import fir_df_pkg::*;

  localparam int IDLE_MAX    = 18;
  localparam int SETTLE      = 20;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASES      = 16;
  localparam logic signed [63:0] OUT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_LO = -OUT_HI - 64'sd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_write = 1'b0;
  logic [TAP_COUNT_BITS-1:0] cfg_data = '0;

  fir_filter_direct_form_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic signed [COEF_BITS-1:0] coef_mem [MAX_TAPS];
  logic [ADDR_BITS-1:0] newest;
  int unsigned taps_used = TAP_COUNT_RESET;

  in_t stimulus_q[$];
  out_t filtered_q[$];
  int errors = 0;
  int unsigned cycles = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  int unsigned count_plan [PHASES] = '{1, 0, 2, 2047, 5, 50, 1024, 17,
                                       3, 64, 1025, 8, 33, 0, 150, 11};

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic predict_filter(input in_t item);
    logic signed [63:0] acc;
    logic signed [63:0] y;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [ADDR_BITS-1:0] pos;
    int unsigned n;
    out_t r;
    if (item.command == CMD_TAP) begin
      coef_mem[item.tap_index] = item.tap_value;
    end else begin
      newest = newest - 1'b1;
      hist_mem[newest] = item.sample;
      n = (taps_used > MAX_TAPS) ? MAX_TAPS : taps_used;
      acc = '0;
      for (int i = 0; i < n; i++) begin
        pos = newest + i[ADDR_BITS-1:0];
        a = hist_mem[pos];
        b = coef_mem[i];
        acc = acc + a * b;
      end
      y = acc >>> FRAC_BITS;
      r.saturated = 1'b0;
      if (y > OUT_HI) begin
        y = OUT_HI;
        r.saturated = 1'b1;
      end else if (y < OUT_LO) begin
        y = OUT_LO;
        r.saturated = 1'b1;
      end
      r.filtered = y[SAMPLE_BITS-1:0];
      filtered_q.push_back(r);
    end
  endtask

  function automatic in_t tap_item(int idx, int coef);
    in_t it;
    it.command = CMD_TAP;
    it.tap_index = idx[TAP_INDEX_BITS-1:0];
    it.tap_value = coef[COEF_BITS-1:0];
    it.sample = $urandom;
    return it;
  endfunction

  function automatic in_t sample_item(int smp);
    in_t it;
    it.command = CMD_SAMPLE;
    it.tap_index = $urandom;
    it.tap_value = $urandom;
    it.sample = smp[SAMPLE_BITS-1:0];
    return it;
  endfunction

  function automatic int random_value();
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0: return 32767;
      1: return -32768;
      2: return int'($urandom_range(0, 2)) - 1;
      3, 4: return int'($urandom_range(0, 2047)) - 1024;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic in_t random_item(int unsigned span);
    int idx;
    if (span == 0 || $urandom_range(0, 3) == 0) begin
      idx = $urandom_range(0, MAX_TAPS - 1);
    end else begin
      idx = $urandom_range(0, span - 1);
    end
    if ($urandom_range(0, 99) < 30) begin
      return tap_item(idx, random_value());
    end
    return sample_item(random_value());
  endfunction

  task automatic wait_drained();
    while (stimulus_q.size() != 0 || in_valid || filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        predict_filter(in_data);
        void'(stimulus_q.pop_front());
        next_valid = 1'b0;
        in_gap = in_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      end
      if (!next_valid) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (stimulus_q.size() != 0) begin
          next_valid = 1'b1;
          in_data <= stimulus_q[0];
        end
      end
      in_valid <= next_valid;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          errors++;
          $display("%0t unexpected transaction: expected none, actual filtered %0d saturated %0b",
                   $time, out_data.filtered, out_data.saturated);
        end else begin
          want = filtered_q.pop_front();
          if (out_data.filtered !== want.filtered) begin
            errors++;
            $display("%0t filtered mismatch: expected %0d, actual %0d",
                     $time, want.filtered, out_data.filtered);
          end
          if (out_data.saturated !== want.saturated) begin
            errors++;
            $display("%0t saturated mismatch: expected %0b, actual %0b",
                     $time, want.saturated, out_data.saturated);
          end
        end
        out_hold = out_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      end else if (out_valid && out_hold != 0) begin
        out_hold--;
      end
      out_stall <= (out_hold != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned span;
    int unsigned n_items;
    for (int i = 0; i < MAX_TAPS; i++) begin
      hist_mem[i] = '0;
      coef_mem[i] = '0;
    end
    newest = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    stimulus_q.push_back(sample_item(32767));
    stimulus_q.push_back(tap_item(0, -32768));
    stimulus_q.push_back(sample_item(-32768));
    stimulus_q.push_back(tap_item(1, 32767));
    stimulus_q.push_back(tap_item(1023, -1));
    stimulus_q.push_back(sample_item(32767));
    stimulus_q.push_back(tap_item(0, 32767));
    stimulus_q.push_back(sample_item(32767));
    stimulus_q.push_back(sample_item(-1));
    stimulus_q.push_back(sample_item(1));
    stimulus_q.push_back(tap_item(1, 0));
    stimulus_q.push_back(sample_item(-1));
    stimulus_q.push_back(tap_item(2, 1));
    stimulus_q.push_back(tap_item(49, 16384));
    stimulus_q.push_back(tap_item(50, 32767));
    stimulus_q.push_back(sample_item(0));
    stimulus_q.push_back(sample_item(100));
    stimulus_q.push_back(sample_item(-100));
    stimulus_q.push_back(tap_item(512, 21845));
    stimulus_q.push_back(tap_item(341, -21846));
    stimulus_q.push_back(sample_item(-32768));
    stimulus_q.push_back(sample_item(32767));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      span = count_plan[p];
      if (p == PHASES - 2) begin
        span = $urandom_range(100, 300);
      end
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_data <= span[TAP_COUNT_BITS-1:0];
      @(posedge clk);
      cfg_write <= 1'b0;
      taps_used = span;
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      @(negedge clk);
      n_items = (span >= 512) ? 8 : 42;
      repeat (n_items) stimulus_q.push_back(random_item((span > MAX_TAPS) ? MAX_TAPS : span));
      wait_drained();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
